### rtl/mrsp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI running-status parser package
// Byte classification constants and the result record shared by the parser
// core and the top level.
// ----------------------------------------------------------------------------
package mrsp_pkg;

  localparam logic [7:0] RT_FIRST   = 8'hF8;
  localparam logic [7:0] RT_LAST    = 8'hFF;
  localparam logic [7:0] SYS_FIRST  = 8'hF0;
  localparam logic [7:0] SYS_LAST   = 8'hF7;
  localparam logic [7:0] CHAN_FIRST = 8'h80;
  localparam logic [7:0] CHAN_LAST  = 8'hEF;
  localparam logic [7:0] TYPE_MASK  = 8'hF0;
  localparam logic [7:0] TYPE_PROG  = 8'hC0;
  localparam logic [7:0] TYPE_PRESS = 8'hD0;
  localparam logic [7:0] NO_STATUS  = 8'h00;

  localparam logic [1:0] NEED_NONE  = 2'd0;
  localparam logic [1:0] NEED_ONE   = 2'd1;
  localparam logic [1:0] NEED_TWO   = 2'd2;

  typedef struct packed {
    logic       emit;
    logic [7:0] status_byte;
    logic [6:0] first_data;
    logic [6:0] second_data;
  } mrsp_result_t;

endpackage

### rtl/mrsp_core.sv
// ----------------------------------------------------------------------------
// MIDI running-status parser core
// Holds the running status and the partly collected message, and works out
// in one pass whether a byte completes a channel message.
// ----------------------------------------------------------------------------
module mrsp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 beat_i,
  input  logic [7:0]           byte_i,
  output mrsp_pkg::mrsp_result_t res_o
);

  logic [7:0] status_q, status_d;
  logic [1:0] needed_q, needed_d;
  logic       idx_q, idx_d;
  logic [6:0] held_q, held_d;
  logic [7:0] type_nib;

  assign type_nib = byte_i & mrsp_pkg::TYPE_MASK;

  always_comb begin
    status_d          = status_q;
    needed_d          = needed_q;
    idx_d             = idx_q;
    held_d            = held_q;
    res_o.emit        = 1'b0;
    res_o.status_byte = status_q;
    res_o.first_data  = byte_i[6:0];
    res_o.second_data = 7'd0;
    case (byte_i) inside
      [mrsp_pkg::RT_FIRST:mrsp_pkg::RT_LAST]: begin
      end
      [mrsp_pkg::SYS_FIRST:mrsp_pkg::SYS_LAST]: begin
        status_d = mrsp_pkg::NO_STATUS;
        needed_d = mrsp_pkg::NEED_NONE;
        idx_d    = 1'b0;
      end
      [mrsp_pkg::CHAN_FIRST:mrsp_pkg::CHAN_LAST]: begin
        status_d = byte_i;
        idx_d    = 1'b0;
        if (type_nib == mrsp_pkg::TYPE_PROG || type_nib == mrsp_pkg::TYPE_PRESS) begin
          needed_d = mrsp_pkg::NEED_ONE;
        end else begin
          needed_d = mrsp_pkg::NEED_TWO;
        end
      end
      default: begin
        if (status_q != mrsp_pkg::NO_STATUS && needed_q != mrsp_pkg::NEED_NONE) begin
          if (needed_q == mrsp_pkg::NEED_ONE) begin
            held_d     = byte_i[6:0];
            idx_d      = 1'b0;
            res_o.emit = 1'b1;
          end else if (!idx_q) begin
            held_d = byte_i[6:0];
            idx_d  = 1'b1;
          end else begin
            idx_d             = 1'b0;
            res_o.emit        = 1'b1;
            res_o.first_data  = held_q;
            res_o.second_data = byte_i[6:0];
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= mrsp_pkg::NO_STATUS;
      needed_q <= mrsp_pkg::NEED_NONE;
      idx_q    <= 1'b0;
    end else if (beat_i) begin
      status_q <= status_d;
      needed_q <= needed_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i) begin
      held_q <= held_d;
    end
  end

endmodule

### rtl/midi_running_status_parser_unit.sv
// ----------------------------------------------------------------------------
// MIDI running-status parser
// Turns a raw MIDI byte stream into complete channel voice messages, keeping
// running status; real-time bytes are ignored, system bytes cancel it.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_ready_o  midi_byte_i
//   out      output     out_valid_o / out_ready_i status_byte_o, first_data_o,
//                                                second_data_o
//
// One beat is taken every cycle unless the output stalls; a byte passes an
// input register and the parser logic, and its message is registered in the
// result register. While a result waits, the input register takes one more
// beat and then stalls until the result is taken.
// Reset clears the running status and all handshake state.
// ----------------------------------------------------------------------------
module midi_running_status_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] midi_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] status_byte_o,
  output logic [6:0] first_data_o,
  output logic [6:0] second_data_o
);

  logic                  in_valid_q, in_valid_d;
  logic [7:0]            byte_q;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            status_q;
  logic [6:0]            first_q;
  logic [6:0]            second_q;
  logic                  advance;
  mrsp_pkg::mrsp_result_t res;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  mrsp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (advance),
    .byte_i (byte_q),
    .res_o  (res)
  );

  always_comb begin
    in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res.emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= midi_byte_i;
    end
    if (advance && res.emit) begin
      status_q <= res.status_byte;
      first_q  <= res.first_data;
      second_q <= res.second_data;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_byte_o = status_q;
  assign first_data_o  = first_q;
  assign second_data_o = second_q;

  a_status_is_channel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_byte_o[7] && status_byte_o[7:4] != 4'hF))
    else $error("result carries a status byte that is not a channel status");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the result register could move");

  a_held_byte_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(byte_q)))
    else $error("buffered byte lost while the output was blocked");

endmodule

### tb/midi_running_status_parser_unit_test.sv
// ----------------------------------------------------------------------------
// MIDI running-status parser unit test
// Feeds the parser a directed byte stream and then about 1600 random beats of
// well-formed messages, broken messages and noise. Expected messages come
// from the directed table or a behavioural copy of the parser. Each message
// taken from the output is compared field by field with the oldest one. Both
// sides idle at random, the receiver holds off once for a long stretch, and
// the sender drains the parser once before the random stream starts.
// ----------------------------------------------------------------------------
module midi_running_status_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BEATS = 1600;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 4;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] first_data;
    logic [6:0] second_data;
  } midi_msg_t;

  typedef enum logic [1:0] {
    ROW_QUIET,
    ROW_EMITS,
    ROW_MODEL
  } row_kind_e;

  typedef struct {
    logic [7:0] beat_byte;
    row_kind_e  kind;
    midi_msg_t  msg;
  } byte_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] midi_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] status_byte_o;
  logic [6:0] first_data_o;
  logic [6:0] second_data_o;

  midi_running_status_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .midi_byte_i   (midi_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_byte_o (status_byte_o),
    .first_data_o  (first_data_o),
    .second_data_o (second_data_o)
  );

  // Running-status tracker state.
  logic [7:0] cur_status = mrsp_pkg::NO_STATUS;
  logic [6:0] held_data  = 7'd0;
  logic [1:0] data_count = 2'd0;
  logic [1:0] need_count = mrsp_pkg::NEED_NONE;

  midi_msg_t  expected_msgs[$];
  int         errors       = 0;
  int         quiet_cycles = 0;
  int         send_burst   = 0;
  int         recv_burst   = 0;
  int         random_sent  = 0;
  bit         hold_req     = 1'b0;

  byte_row_t directed_rows[26] = '{
    '{8'h40, ROW_QUIET, '0},
    '{8'h90, ROW_QUIET, '0},
    '{8'h00, ROW_QUIET, '0},
    '{8'hF8, ROW_QUIET, '0},
    '{8'h7F, ROW_EMITS, '{8'h90, 7'h00, 7'h7F}},
    '{8'h3C, ROW_QUIET, '0},
    '{8'h40, ROW_EMITS, '{8'h90, 7'h3C, 7'h40}},
    '{8'hEF, ROW_QUIET, '0},
    '{8'h7F, ROW_QUIET, '0},
    '{8'h8F, ROW_QUIET, '0},
    '{8'h01, ROW_QUIET, '0},
    '{8'h02, ROW_EMITS, '{8'h8F, 7'h01, 7'h02}},
    '{8'hC0, ROW_QUIET, '0},
    '{8'h7F, ROW_EMITS, '{8'hC0, 7'h7F, 7'h00}},
    '{8'h00, ROW_EMITS, '{8'hC0, 7'h00, 7'h00}},
    '{8'hDF, ROW_QUIET, '0},
    '{8'h55, ROW_EMITS, '{8'hDF, 7'h55, 7'h00}},
    '{8'hF0, ROW_QUIET, '0},
    '{8'h12, ROW_QUIET, '0},
    '{8'hF7, ROW_QUIET, '0},
    '{8'hA5, ROW_MODEL, '0},
    '{8'hFF, ROW_MODEL, '0},
    '{8'h11, ROW_MODEL, '0},
    '{8'h22, ROW_MODEL, '0},
    '{8'hB3, ROW_MODEL, '0},
    '{8'h7E, ROW_MODEL, '0}
  };

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [1:0] data_len(input logic [7:0] status);
    logic [7:0] kind;
    kind = status & mrsp_pkg::TYPE_MASK;
    if (kind == mrsp_pkg::TYPE_PROG || kind == mrsp_pkg::TYPE_PRESS) return mrsp_pkg::NEED_ONE;
    return mrsp_pkg::NEED_TWO;
  endfunction

  task automatic predict_beat(input logic [7:0] b, output bit emitted, output midi_msg_t msg);
    emitted = 1'b0;
    msg     = '0;
    if (b >= mrsp_pkg::RT_FIRST) begin
    end else if (b[7]) begin
      data_count = 2'd0;
      if (b >= mrsp_pkg::SYS_FIRST) begin
        cur_status = mrsp_pkg::NO_STATUS;
        need_count = mrsp_pkg::NEED_NONE;
      end else begin
        cur_status = b;
        need_count = data_len(b);
      end
    end else if (cur_status != mrsp_pkg::NO_STATUS && need_count != mrsp_pkg::NEED_NONE) begin
      if (need_count == mrsp_pkg::NEED_ONE) begin
        held_data  = b[6:0];
        data_count = 2'd0;
        emitted    = 1'b1;
        msg        = '{cur_status, b[6:0], 7'd0};
      end else if (data_count == 2'd0) begin
        held_data  = b[6:0];
        data_count = 2'd1;
      end else begin
        data_count = 2'd0;
        emitted    = 1'b1;
        msg        = '{cur_status, held_data, b[6:0]};
      end
    end
  endtask

  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  task automatic send_beat(input logic [7:0] b, input row_kind_e kind, input midi_msg_t typed_msg);
    int        gap;
    bit        emitted;
    midi_msg_t msg;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    midi_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_beat(b, emitted, msg);
    if (kind == ROW_MODEL) begin
      if (emitted) expected_msgs.push_back(msg);
    end else if (kind == ROW_EMITS) begin
      expected_msgs.push_back(typed_msg);
    end
  endtask

  // Real-time bytes are sprinkled in now and then; they count as beats too.
  task automatic send_mixed(input logic [7:0] b);
    logic [7:0] rt_byte;
    if ($urandom_range(0, 9) == 0) begin
      rt_byte = 8'($urandom_range(mrsp_pkg::RT_FIRST, mrsp_pkg::RT_LAST));
      send_beat(rt_byte, ROW_MODEL, '0);
      random_sent++;
    end
    send_beat(b, ROW_MODEL, '0);
    random_sent++;
  endtask

  initial begin
    int roll;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(directed_rows); i++) begin
      send_beat(directed_rows[i].beat_byte, directed_rows[i].kind, directed_rows[i].msg);
    end

    in_valid_i <= 1'b0;
    while (expected_msgs.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    hold_req = 1'b1;
    while (random_sent < RANDOM_BEATS) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        if (roll >= 25 || need_count == mrsp_pkg::NEED_NONE) begin
          send_mixed(8'($urandom_range(mrsp_pkg::CHAN_FIRST, mrsp_pkg::CHAN_LAST)));
        end
        for (int k = 0; k < need_count; k++) send_mixed({1'b0, 7'($urandom_range(0, 127))});
      end else if (roll < 88) begin
        send_mixed(8'($urandom_range(mrsp_pkg::CHAN_FIRST, mrsp_pkg::CHAN_LAST)));
        send_mixed({1'b0, 7'($urandom_range(0, 127))});
        if ($urandom_range(0, 1) == 1) begin
          send_mixed(8'($urandom_range(mrsp_pkg::SYS_FIRST, mrsp_pkg::SYS_LAST)));
        end
      end else begin
        send_mixed(8'($urandom_range(0, 255)));
      end
    end

    in_valid_i <= 1'b0;
    while (expected_msgs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_msgs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    int        stall;
    midi_msg_t want;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end else begin
        stall = draw_wait(recv_burst);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_msgs.size() == 0) begin
        errors++;
        $display("%0t: unexpected message status %h data %h %h", $time, status_byte_o,
                 first_data_o, second_data_o);
      end else begin
        want = expected_msgs.pop_front();
        if (status_byte_o !== want.status_byte) begin
          errors++;
          $display("%0t: status_byte expected %h actual %h", $time, want.status_byte,
                   status_byte_o);
        end
        if (first_data_o !== want.first_data) begin
          errors++;
          $display("%0t: first_data expected %h actual %h", $time, want.first_data,
                   first_data_o);
        end
        if (second_data_o !== want.second_data) begin
          errors++;
          $display("%0t: second_data expected %h actual %h", $time, want.second_data,
                   second_data_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

### files.f
rtl/mrsp_pkg.sv
rtl/mrsp_core.sv
rtl/midi_running_status_parser_unit.sv
tb/midi_running_status_parser_unit_test.sv
